// File: design/dpcr_pkg.sv
// ---------------------------------------------------------------------------
// dpcr_pkg
// Shared types and helpers for the disc pair collision resolver.
// ---------------------------------------------------------------------------
package dpcr_pkg;

  localparam int unsigned CD_W = 31;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_a_x;
    logic signed [31:0] new_pos_a_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_pos_b_x;
    logic signed [31:0] new_pos_b_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic               collided;
  } out_t;

  // item, its centre offset and contact flag, carried alongside the root and divide stages
  typedef struct packed {
    in_t                item;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               hit;
  } front_t;

  // arithmetic shift right rounding toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/dpcr_isqrt.sv
// ---------------------------------------------------------------------------
// dpcr_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ---------------------------------------------------------------------------
module dpcr_isqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [63:0]      in_d2,
  input  dpcr_pkg::front_t in_side,
  output logic             out_vld,
  output logic [31:0]      out_root,
  output dpcr_pkg::front_t out_side
);
  import dpcr_pkg::*;

  localparam int unsigned NS = 32;

  logic [34:0] rem_r  [NS];
  logic [31:0] root_r [NS];
  logic [63:0] val_r  [NS];
  front_t      side_r [NS];
  logic        vld_r  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] val_in;
    front_t      side_in;
    logic        vld_in;
    logic [34:0] tmp;
    logic [34:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = in_d2;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign val_in  = val_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign tmp   = {rem_in[32:0], val_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (tmp - trial) : tmp;
        root_r[i] <= {root_in[30:0], ge};
        val_r[i]  <= {val_in[61:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_root = root_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

// File: design/dpcr_norm.sv
// ---------------------------------------------------------------------------
// dpcr_norm
// Pipelined unit normal: offset over distance, one quotient bit per stage.
// ---------------------------------------------------------------------------
module dpcr_norm #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [31:0]                     in_dist,
  input  dpcr_pkg::front_t                in_side,
  output logic                            out_vld,
  output logic signed [FRACTION_BITS+1:0] out_nx,
  output logic signed [FRACTION_BITS+1:0] out_ny,
  output logic [dpcr_pkg::CD_W-1:0]       out_dist,
  output dpcr_pkg::front_t                out_side
);
  import dpcr_pkg::*;

  localparam int unsigned NS = FRACTION_BITS + 1;

  logic [31:0]     rx_r   [NS];
  logic [31:0]     ry_r   [NS];
  logic [NS-1:0]   qx_r   [NS];
  logic [NS-1:0]   qy_r   [NS];
  logic [CD_W-1:0] den_r  [NS];
  front_t          side_r [NS];
  logic            vld_r  [NS];

  logic [32:0] adx;
  logic [32:0] ady;

  assign adx = in_side.dx[32] ? 33'(-in_side.dx) : 33'(in_side.dx);
  assign ady = in_side.dy[32] ? 33'(-in_side.dy) : 33'(in_side.dy);

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [31:0]     rx_in;
    logic [31:0]     ry_in;
    logic [NS-1:0]   qx_in;
    logic [NS-1:0]   qy_in;
    logic [CD_W-1:0] den_in;
    front_t          side_in;
    logic            vld_in;
    logic            gex;
    logic            gey;
    logic [31:0]     rx_sub;
    logic [31:0]     ry_sub;

    if (i == 0) begin : g_first
      assign rx_in   = adx[31:0];
      assign ry_in   = ady[31:0];
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = in_dist[CD_W-1:0];
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rx_in   = rx_r[i-1];
      assign ry_in   = ry_r[i-1];
      assign qx_in   = qx_r[i-1];
      assign qy_in   = qy_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign gex    = (rx_in >= {1'b0, den_in});
    assign gey    = (ry_in >= {1'b0, den_in});
    assign rx_sub = gex ? (rx_in - {1'b0, den_in}) : rx_in;
    assign ry_sub = gey ? (ry_in - {1'b0, den_in}) : ry_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[i]   <= {rx_sub[30:0], 1'b0};
        ry_r[i]   <= {ry_sub[30:0], 1'b0};
        qx_r[i]   <= {qx_in[NS-2:0], gex};
        qy_r[i]   <= {qy_in[NS-2:0], gey};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  logic signed [FRACTION_BITS+1:0] qx_s;
  logic signed [FRACTION_BITS+1:0] qy_s;

  assign qx_s     = {1'b0, qx_r[NS-1]};
  assign qy_s     = {1'b0, qy_r[NS-1]};
  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
  assign out_dist = den_r[NS-1];
  assign out_nx   = side_r[NS-1].dx[32] ? -qx_s : qx_s;
  assign out_ny   = side_r[NS-1].dy[32] ? -qy_s : qy_s;

endmodule

// File: design/disc_pair_collision_resolve.sv
// ---------------------------------------------------------------------------
// disc_pair_collision_resolve
// Equal-mass elastic collision of two discs in signed fixed point.
// ---------------------------------------------------------------------------
// One disc pair enters per clock unless the pipe is held. Each pair passes
// through the offset and squared-distance registers, the square root at one
// root bit per stage, the normal division at one quotient bit per stage,
// and the impulse, push-apart and saturation registers, the last being the
// output register. The whole pipe holds while a result waits on out_ready.
// The user must write cfg_data, which sets the contact distance, only while
// no pair is in flight; the block itself does not enforce this.
module disc_pair_collision_resolve #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dpcr_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dpcr_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpcr_pkg::CD_W-1:0]      cfg_data
);
  import dpcr_pkg::*;

  localparam int NW  = FRACTION_BITS + 2;
  localparam int PW  = FRACTION_BITS + 36;
  localparam int CW  = FRACTION_BITS + 35;
  localparam int SW  = FRACTION_BITS + 37;
  localparam int VW  = 37;
  localparam int IW  = VW + NW;
  localparam logic [CD_W-1:0] CD_RESET = 31'd1310720;

  logic            en;
  logic [CD_W-1:0] cd_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= CD_RESET;
    end else if (cfg_valid) begin
      cd_r <= cfg_data;
    end
  end

  // offset
  logic               f1_vld_r;
  in_t                f1_item_r;
  logic signed [32:0] f1_dx_r;
  logic signed [32:0] f1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_item_r <= in_data;
      f1_dx_r   <= 33'(in_data.pos_a_x) - 33'(in_data.pos_b_x);
      f1_dy_r   <= 33'(in_data.pos_a_y) - 33'(in_data.pos_b_y);
    end
  end

  // squares
  logic [32:0] adx;
  logic [32:0] ady;
  logic        near_nxt;

  assign adx      = f1_dx_r[32] ? 33'(-f1_dx_r) : 33'(f1_dx_r);
  assign ady      = f1_dy_r[32] ? 33'(-f1_dy_r) : 33'(f1_dy_r);
  assign near_nxt = (adx <= {2'b00, cd_r}) && (ady <= {2'b00, cd_r});

  logic               f2_vld_r;
  in_t                f2_item_r;
  logic signed [32:0] f2_dx_r;
  logic signed [32:0] f2_dy_r;
  logic               f2_near_r;
  logic [63:0]        f2_dxx_r;
  logic [63:0]        f2_dyy_r;
  logic [61:0]        f2_cd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_item_r <= f1_item_r;
      f2_dx_r   <= f1_dx_r;
      f2_dy_r   <= f1_dy_r;
      f2_near_r <= near_nxt;
      f2_dxx_r  <= 64'(adx[31:0]) * 64'(adx[31:0]);
      f2_dyy_r  <= 64'(ady[31:0]) * 64'(ady[31:0]);
      f2_cd2_r  <= 62'(cd_r) * 62'(cd_r);
    end
  end

  // squared distance and contact test
  logic [63:0] d2_nxt;
  front_t      side_nxt;

  assign d2_nxt = f2_dxx_r + f2_dyy_r;

  always_comb begin
    side_nxt.item = f2_item_r;
    side_nxt.dx   = f2_dx_r;
    side_nxt.dy   = f2_dy_r;
    side_nxt.hit  = f2_near_r && (d2_nxt != 64'd0) && (d2_nxt <= {2'b00, f2_cd2_r});
  end

  logic        f3_vld_r;
  front_t      f3_side_r;
  logic [63:0] f3_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else if (en) begin
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_side_r <= side_nxt;
      f3_d2_r   <= d2_nxt;
    end
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  front_t      sq_side;

  dpcr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f3_vld_r),
    .in_d2    (f3_d2_r),
    .in_side  (f3_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  logic                   nm_vld;
  logic signed [NW-1:0]   nm_nx;
  logic signed [NW-1:0]   nm_ny;
  logic [CD_W-1:0]        nm_dist;
  front_t                 nm_side;

  dpcr_norm #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_dist  (sq_root),
    .in_side  (sq_side),
    .out_vld  (nm_vld),
    .out_nx   (nm_nx),
    .out_ny   (nm_ny),
    .out_dist (nm_dist),
    .out_side (nm_side)
  );

  // products with the normal
  logic signed [32:0] rvx;
  logic signed [32:0] rvy;
  logic signed [32:0] pen;

  assign rvx = 33'(nm_side.item.vel_a_x) - 33'(nm_side.item.vel_b_x);
  assign rvy = 33'(nm_side.item.vel_a_y) - 33'(nm_side.item.vel_b_y);
  assign pen = 33'({1'b0, cd_r}) - 33'({1'b0, nm_dist});

  logic                 m1_vld_r;
  in_t                  m1_item_r;
  logic                 m1_hit_r;
  logic signed [NW-1:0] m1_nx_r;
  logic signed [NW-1:0] m1_ny_r;
  logic signed [PW-1:0] m1_px_r;
  logic signed [PW-1:0] m1_py_r;
  logic signed [CW-1:0] m1_cx_r;
  logic signed [CW-1:0] m1_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= nm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_item_r <= nm_side.item;
      m1_hit_r  <= nm_side.hit;
      m1_nx_r   <= nm_nx;
      m1_ny_r   <= nm_ny;
      m1_px_r   <= PW'(rvx) * PW'(nm_nx);
      m1_py_r   <= PW'(rvy) * PW'(nm_ny);
      m1_cx_r   <= CW'(nm_nx) * CW'(pen);
      m1_cy_r   <= CW'(nm_ny) * CW'(pen);
    end
  end

  // normal speed and push-apart
  logic signed [SW-1:0] s_sum;
  logic signed [63:0]   vn_full;
  logic signed [63:0]   cx_full;
  logic signed [63:0]   cy_full;

  assign s_sum   = SW'(m1_px_r) + SW'(m1_py_r);
  assign vn_full = trunc_shr(64'(s_sum), FRACTION_BITS);
  assign cx_full = trunc_shr(64'(m1_cx_r), FRACTION_BITS + 1);
  assign cy_full = trunc_shr(64'(m1_cy_r), FRACTION_BITS + 1);

  logic                 m2_vld_r;
  in_t                  m2_item_r;
  logic                 m2_hit_r;
  logic signed [NW-1:0] m2_nx_r;
  logic signed [NW-1:0] m2_ny_r;
  logic signed [VW-1:0] m2_vn_r;
  logic signed [32:0]   m2_cx_r;
  logic signed [32:0]   m2_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_item_r <= m1_item_r;
      m2_hit_r  <= m1_hit_r && !(s_sum > 0);
      m2_nx_r   <= m1_nx_r;
      m2_ny_r   <= m1_ny_r;
      m2_vn_r   <= vn_full[VW-1:0];
      m2_cx_r   <= cx_full[32:0];
      m2_cy_r   <= cy_full[32:0];
    end
  end

  // impulse products
  logic                 m3_vld_r;
  in_t                  m3_item_r;
  logic                 m3_hit_r;
  logic signed [IW-1:0] m3_ix_r;
  logic signed [IW-1:0] m3_iy_r;
  logic signed [32:0]   m3_cx_r;
  logic signed [32:0]   m3_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_item_r <= m2_item_r;
      m3_hit_r  <= m2_hit_r;
      m3_ix_r   <= IW'(m2_vn_r) * IW'(m2_nx_r);
      m3_iy_r   <= IW'(m2_vn_r) * IW'(m2_ny_r);
      m3_cx_r   <= m2_cx_r;
      m3_cy_r   <= m2_cy_r;
    end
  end

  // apply and saturate
  logic signed [63:0] ix;
  logic signed [63:0] iy;
  logic signed [63:0] cx;
  logic signed [63:0] cy;
  out_t               res_nxt;

  assign ix = trunc_shr(64'(m3_ix_r), FRACTION_BITS);
  assign iy = trunc_shr(64'(m3_iy_r), FRACTION_BITS);
  assign cx = 64'(m3_cx_r);
  assign cy = 64'(m3_cy_r);

  always_comb begin
    if (m3_hit_r) begin
      res_nxt.new_pos_a_x = sat32(64'(m3_item_r.pos_a_x) + cx);
      res_nxt.new_pos_a_y = sat32(64'(m3_item_r.pos_a_y) + cy);
      res_nxt.new_vel_a_x = sat32(64'(m3_item_r.vel_a_x) - ix);
      res_nxt.new_vel_a_y = sat32(64'(m3_item_r.vel_a_y) - iy);
      res_nxt.new_pos_b_x = sat32(64'(m3_item_r.pos_b_x) - cx);
      res_nxt.new_pos_b_y = sat32(64'(m3_item_r.pos_b_y) - cy);
      res_nxt.new_vel_b_x = sat32(64'(m3_item_r.vel_b_x) + ix);
      res_nxt.new_vel_b_y = sat32(64'(m3_item_r.vel_b_y) + iy);
      res_nxt.collided    = 1'b1;
    end else begin
      res_nxt.new_pos_a_x = m3_item_r.pos_a_x;
      res_nxt.new_pos_a_y = m3_item_r.pos_a_y;
      res_nxt.new_vel_a_x = m3_item_r.vel_a_x;
      res_nxt.new_vel_a_y = m3_item_r.vel_a_y;
      res_nxt.new_pos_b_x = m3_item_r.pos_b_x;
      res_nxt.new_pos_b_y = m3_item_r.pos_b_y;
      res_nxt.new_vel_b_x = m3_item_r.vel_b_x;
      res_nxt.new_vel_b_y = m3_item_r.vel_b_y;
      res_nxt.collided    = 1'b0;
    end
  end

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
